@@ rtl/core/two_class_budget_rr_scheduler_defines.svh @@
// Assertion macros for the two-class round-robin scheduler.
// Included by the top level; no other dependencies.
`ifndef TWO_CLASS_BUDGET_RR_SCHEDULER_DEFINES_SVH
`define TWO_CLASS_BUDGET_RR_SCHEDULER_DEFINES_SVH

`ifndef SYNTHESIS
`define TCBRS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tcbrs check failed");
`define TCBRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tcbrs check failed");
`else
`define TCBRS_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define TCBRS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ rtl/core/tcbrs_pkg.sv @@
// Package for the two-class round-robin scheduler: sizes, types and helper functions.
// No dependencies.
package tcbrs_pkg;

   localparam int NUM_BUCKETS = 16;
   localparam int FIFO_DEPTH = 8;
   localparam int TAG_BITS = 8;

   localparam int TAG_FIELD_W = 8;
   localparam int BUCKET_FIELD_W = 4;
   localparam int LIMIT_W = 8;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd6;

   localparam int BKT_W = $clog2(NUM_BUCKETS);
   localparam int SLOT_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam int IDX_W = BKT_W + 1;
   localparam int META_DEPTH = 2 ** IDX_W;
   localparam int TAG_ADDR_W = IDX_W + SLOT_W;
   localparam int TAG_DEPTH = 2 ** TAG_ADDR_W;

   localparam logic REQ_ENQUEUE = 1'b0;
   localparam logic REQ_DISPATCH = 1'b1;
   localparam logic CLASS_BG = 1'b0;
   localparam logic CLASS_SYNC = 1'b1;

   typedef struct packed {
      logic [SLOT_W-1:0] head;
      logic [CNT_W-1:0]  count;
   } meta_type;

   typedef struct packed {
      logic             found;
      logic [BKT_W-1:0] bkt;
   } rr_pick_type;

   function automatic logic [BKT_W-1:0] bucket_wrap(input logic [BUCKET_FIELD_W-1:0] b);
      logic [BKT_W+BUCKET_FIELD_W:0] v;
      v = {{(BKT_W + 1){1'b0}}, b};
      for (int i = 0; i < 8; i++) begin
         if (v >= (BKT_W + BUCKET_FIELD_W + 1)'(NUM_BUCKETS)) begin
            v = v - (BKT_W + BUCKET_FIELD_W + 1)'(NUM_BUCKETS);
         end
      end
      return v[BKT_W-1:0];
   endfunction

   function automatic logic [BUCKET_FIELD_W-1:0] bucket_field(input logic [BKT_W-1:0] b);
      logic [BKT_W+BUCKET_FIELD_W-1:0] w;
      w = {{BUCKET_FIELD_W{1'b0}}, b};
      return w[BUCKET_FIELD_W-1:0];
   endfunction

   function automatic logic [TAG_BITS-1:0] tag_store_value(input logic [TAG_FIELD_W-1:0] t);
      logic [TAG_BITS+TAG_FIELD_W-1:0] w;
      w = {{TAG_BITS{1'b0}}, t};
      return w[TAG_BITS-1:0];
   endfunction

   function automatic logic [TAG_FIELD_W-1:0] tag_field(input logic [TAG_BITS-1:0] t);
      logic [TAG_BITS+TAG_FIELD_W-1:0] w;
      w = {{TAG_FIELD_W{1'b0}}, t};
      return w[TAG_FIELD_W-1:0];
   endfunction

   function automatic logic [BKT_W-1:0] bkt_next(input logic [BKT_W-1:0] b);
      return (b == BKT_W'(NUM_BUCKETS - 1)) ? '0 : b + BKT_W'(1);
   endfunction

   function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
      return (s == SLOT_W'(FIFO_DEPTH - 1)) ? '0 : s + SLOT_W'(1);
   endfunction

   function automatic logic [SLOT_W-1:0] tail_slot(input logic [SLOT_W-1:0] head,
                                                    input logic [CNT_W-1:0] count);
      logic [CNT_W:0] s;
      s = (CNT_W + 1)'(head) + (CNT_W + 1)'(count);
      if (s >= (CNT_W + 1)'(FIFO_DEPTH)) begin
         s = s - (CNT_W + 1)'(FIFO_DEPTH);
      end
      return s[SLOT_W-1:0];
   endfunction

   function automatic rr_pick_type rr_pick(input logic [NUM_BUCKETS-1:0] occ,
                                           input logic [BKT_W-1:0] ptr);
      logic [NUM_BUCKETS-1:0] upper;
      rr_pick_type r;
      upper = occ & ~((NUM_BUCKETS'(1) << ptr) - NUM_BUCKETS'(1));
      r = '0;
      for (int i = NUM_BUCKETS - 1; i >= 0; i--) begin
         if (occ[i]) begin
            r.bkt = BKT_W'(i);
         end
      end
      for (int i = NUM_BUCKETS - 1; i >= 0; i--) begin
         if (upper[i]) begin
            r.bkt = BKT_W'(i);
         end
      end
      r.found = |occ;
      return r;
   endfunction

endpackage

@@ rtl/core/two_class_budget_rr_scheduler.sv @@
// Two-class round-robin scheduler with a sync batch budget; uses tcbrs_pkg and the defines header.
// An enqueue or an empty dispatch loads its result once the queue state memory read is back;
// a granted dispatch also waits for the tag memory read, which follows the queue state memory read.
// One item is in work at a time; a new request is taken only once the last result is loaded.
// Synchronous active-high reset empties all queues, zeroes the pointers and the budget,
// and sets the batch limit to 6; the tag memory itself is not cleared.
`include "two_class_budget_rr_scheduler_defines.svh"

module two_class_budget_rr_scheduler (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tcbrs_pkg::LIMIT_W-1:0]        csr_data,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_type,
   input  logic [tcbrs_pkg::TAG_FIELD_W-1:0]    req_tag,
   input  logic                                 req_is_sync,
   input  logic [tcbrs_pkg::BUCKET_FIELD_W-1:0] req_bucket,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_enqueue_accepted,
   output logic                                 rsp_granted,
   output logic [tcbrs_pkg::TAG_FIELD_W-1:0]    rsp_grant_tag,
   output logic                                 rsp_grant_sync,
   output logic [tcbrs_pkg::BUCKET_FIELD_W-1:0] rsp_grant_bucket
);
   import tcbrs_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_META,
      ST_TAG
   } state_type;

   typedef enum logic [1:0] {
      PICK_NONE,
      PICK_SYNC_FIRST,
      PICK_BG,
      PICK_SYNC_FALLBACK
   } pick_kind_type;

   state_type                 state_ff;
   logic                      type_ff;
   logic [IDX_W-1:0]          idx_ff;
   logic [TAG_BITS-1:0]       tag_ff;
   pick_kind_type             pick_ff;

   logic [NUM_BUCKETS-1:0]    occ_ff [2];
   logic [META_DEPTH-1:0]     meta_vld_ff;
   logic [BKT_W-1:0]          rr_ptr_ff [2];
   logic [LIMIT_W-1:0]        budget_ff;
   logic [LIMIT_W-1:0]        limit_ff;

   meta_type                  meta_mem [META_DEPTH];
   meta_type                  meta_rd_ff;
   logic                      meta_rd_vld_ff;
   logic [TAG_BITS-1:0]       tag_mem [TAG_DEPTH];
   logic [TAG_BITS-1:0]       tag_rd_ff;

   logic                      rsp_valid_ff;
   logic                      rsp_enqueue_accepted_ff;
   logic                      rsp_granted_ff;
   logic [TAG_FIELD_W-1:0]    rsp_grant_tag_ff;
   logic                      rsp_grant_sync_ff;
   logic [BUCKET_FIELD_W-1:0] rsp_grant_bucket_ff;

   rr_pick_type               sync_pick;
   rr_pick_type               bg_pick;
   pick_kind_type             pick_in;
   logic [IDX_W-1:0]          idx_in;
   logic                      req_fire;
   logic                      out_free;
   logic [SLOT_W-1:0]         meta_head;
   logic [CNT_W-1:0]          meta_count;
   logic                      can_store;
   logic                      is_dispatch;
   logic                      disp_grant;
   logic                      enq_commit;
   logic                      meta_we;
   meta_type                  meta_wdata;
   logic [LIMIT_W:0]          budget_inc;
   logic [LIMIT_W-1:0]        budget_in;
   logic                      rsp_load;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      sync_pick = rr_pick(occ_ff[CLASS_SYNC], rr_ptr_ff[CLASS_SYNC]);
      bg_pick = rr_pick(occ_ff[CLASS_BG], rr_ptr_ff[CLASS_BG]);
      priority if ((budget_ff < limit_ff) && sync_pick.found) begin
         pick_in = PICK_SYNC_FIRST;
      end else if (bg_pick.found) begin
         pick_in = PICK_BG;
      end else if (sync_pick.found) begin
         pick_in = PICK_SYNC_FALLBACK;
      end else begin
         pick_in = PICK_NONE;
      end
      if (req_type == REQ_ENQUEUE) begin
         idx_in = {req_is_sync, bucket_wrap(req_bucket)};
      end else if (pick_in == PICK_BG) begin
         idx_in = {CLASS_BG, bg_pick.bkt};
      end else begin
         idx_in = {CLASS_SYNC, sync_pick.bkt};
      end
   end

   always_comb begin
      meta_head = meta_rd_vld_ff ? meta_rd_ff.head : '0;
      meta_count = meta_rd_vld_ff ? meta_rd_ff.count : '0;
      can_store = (meta_count < CNT_W'(FIFO_DEPTH));
      is_dispatch = (type_ff == REQ_DISPATCH);
      disp_grant = (state_ff == ST_META) && is_dispatch && (pick_ff != PICK_NONE);
      enq_commit = (state_ff == ST_META) && !is_dispatch && out_free && can_store;
      meta_we = disp_grant || enq_commit;
      rsp_load = out_free && (((state_ff == ST_META) && !disp_grant) || (state_ff == ST_TAG));
      if (is_dispatch) begin
         meta_wdata.head = slot_next(meta_head);
         meta_wdata.count = meta_count - CNT_W'(1);
      end else begin
         meta_wdata.head = meta_head;
         meta_wdata.count = meta_count + CNT_W'(1);
      end
      budget_inc = {1'b0, budget_ff} + (LIMIT_W + 1)'(1);
      unique case (pick_ff)
         PICK_SYNC_FIRST:    budget_in = budget_inc[LIMIT_W-1:0];
         PICK_BG:            budget_in = '0;
         PICK_SYNC_FALLBACK: budget_in = (budget_inc < {1'b0, limit_ff}) ?
                                         budget_inc[LIMIT_W-1:0] : limit_ff;
         default:            budget_in = budget_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         meta_rd_ff <= meta_mem[idx_in];
         meta_rd_vld_ff <= meta_vld_ff[idx_in];
      end
      if (meta_we) begin
         meta_mem[idx_ff] <= meta_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (enq_commit) begin
         tag_mem[{idx_ff, tail_slot(meta_head, meta_count)}] <= tag_ff;
      end
      if (disp_grant) begin
         tag_rd_ff <= tag_mem[{idx_ff, meta_head}];
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         type_ff <= req_type;
         idx_ff <= idx_in;
         tag_ff <= tag_store_value(req_tag);
         pick_ff <= (req_type == REQ_DISPATCH) ? pick_in : PICK_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff[CLASS_BG] <= '0;
         occ_ff[CLASS_SYNC] <= '0;
         meta_vld_ff <= '0;
         rr_ptr_ff[CLASS_BG] <= '0;
         rr_ptr_ff[CLASS_SYNC] <= '0;
         budget_ff <= '0;
         limit_ff <= LIMIT_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_data;
         end
         if (meta_we) begin
            meta_vld_ff[idx_ff] <= 1'b1;
            occ_ff[idx_ff[IDX_W-1]][idx_ff[BKT_W-1:0]] <= (meta_wdata.count != '0);
         end
         if (disp_grant) begin
            rr_ptr_ff[idx_ff[IDX_W-1]] <= bkt_next(idx_ff[BKT_W-1:0]);
            budget_ff <= budget_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  state_ff <= ST_META;
               end
            end
            ST_META: begin
               if (disp_grant) begin
                  state_ff <= ST_TAG;
               end else if (out_free) begin
                  state_ff <= ST_IDLE;
                  rsp_enqueue_accepted_ff <= !is_dispatch && can_store;
                  rsp_granted_ff <= 1'b0;
                  rsp_grant_tag_ff <= '0;
                  rsp_grant_sync_ff <= 1'b0;
                  rsp_grant_bucket_ff <= '0;
               end
            end
            ST_TAG: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
                  rsp_enqueue_accepted_ff <= 1'b0;
                  rsp_granted_ff <= 1'b1;
                  rsp_grant_tag_ff <= tag_field(tag_rd_ff);
                  rsp_grant_sync_ff <= (idx_ff[IDX_W-1] == CLASS_SYNC);
                  rsp_grant_bucket_ff <= bucket_field(idx_ff[BKT_W-1:0]);
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_enqueue_accepted = rsp_enqueue_accepted_ff;
   assign rsp_granted = rsp_granted_ff;
   assign rsp_grant_tag = rsp_grant_tag_ff;
   assign rsp_grant_sync = rsp_grant_sync_ff;
   assign rsp_grant_bucket = rsp_grant_bucket_ff;

   `TCBRS_ASSERT_IMPLIES(a_occ_matches_meta, clock, reset, state_ff == ST_META, occ_ff[idx_ff[IDX_W-1]][idx_ff[BKT_W-1:0]] == (meta_count != '0))
   `TCBRS_ASSERT_IMPLIES(a_tag_only_on_grant, clock, reset, state_ff == ST_TAG, is_dispatch && (pick_ff != PICK_NONE))
   `TCBRS_ASSERT_IMPLIES(a_rsp_exclusive, clock, reset, rsp_valid_ff, !(rsp_granted_ff && rsp_enqueue_accepted_ff))
   `TCBRS_ASSERT_NEXT(a_grant_moves_on, clock, reset, disp_grant, state_ff == ST_TAG)

endmodule
